>>> hw/rtl/ffba_pkg.sv
// Shared types and constants of the first-fit block allocator.
// No dependencies; the core and the checker refer to it by scoped names.
package ffba_pkg;

  localparam int unsigned GRAN_COUNT = 8192;
  localparam int unsigned ADDR_W = $clog2(GRAN_COUNT);
  localparam int unsigned SIZE_W = 14;
  localparam int unsigned ENTRY_W = 16;
  localparam int unsigned HDR_GRAN = 2;
  localparam logic [31:0] HDR_SPAN = 32'd16;
  localparam logic [SIZE_W-1:0] POOL_RESET = 14'd8192;

  localparam logic [2:0] REG_POOL_BASE = 3'd0;
  localparam logic [2:0] REG_POOL_GRANULES = 3'd4;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NONE = 2'd1,
    ST_OOM  = 2'd2,
    ST_BAD  = 2'd3
  } status_t;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_kind_t;

  typedef struct packed {
    logic              valid;
    logic              used;
    logic [SIZE_W-1:0] size;
  } entry_t;

endpackage

>>> hw/rtl/ffba_req_if.sv
// Request channel of the allocator: valid/ready handshake with the request payload.
// Depends on nothing.
interface ffba_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [15:0] size_bytes;
  logic [31:0] address;

  modport source(output valid, req_type, size_bytes, address, input ready);
  modport sink(input valid, req_type, size_bytes, address, output ready);
endinterface

>>> hw/rtl/ffba_rsp_if.sv
// Response channel of the allocator: valid/ready handshake with status and pointer.
// Depends on nothing.
interface ffba_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] address_res;

  modport source(output valid, status, address_res, input ready);
  modport sink(input valid, status, address_res, output ready);
endinterface

>>> hw/rtl/first_fit_block_allocator_core.sv
// First-fit block allocator over a pool of 8-byte granules. The block table lives in one
// RAM; each request walks it from the pool start, one block header per cycle, and one
// transfer is worked on at a time. After reset and after each write of pool_granules the
// table is cleared, during which no request is taken. Depends on ffba_pkg, ffba_req_if,
// ffba_rsp_if and ffba_ram.
module first_fit_block_allocator_core (
  input  logic        clk,
  input  logic        rst,
  ffba_req_if.sink    req,
  ffba_rsp_if.source  rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned AW = ffba_pkg::ADDR_W;
  localparam int unsigned SW = ffba_pkg::SIZE_W;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_A_CHK, S_A_HEAD, S_F_CHK, S_F_NX, S_F_WG, S_F_PW, S_F_CLRG, S_DONE
  } state_t;

  state_t state;
  logic [31:0] pool_base;
  logic [SW-1:0] pool_granules;
  logic [SW-1:0] pool_len;
  logic [AW-1:0] clr_cnt;
  logic [SW-1:0] g;
  logic [SW-1:0] aux;
  logic [SW-1:0] bsz;
  logic [SW:0] needed;
  ffba_pkg::status_t res_status;
  logic [31:0] res_addr;
  logic out_valid;
  logic [1:0] out_status;
  logic [31:0] out_addr;

  logic ram_we;
  logic [AW-1:0] ram_waddr;
  logic [ffba_pkg::ENTRY_W-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [ffba_pkg::ENTRY_W-1:0] ram_rdata;
  ffba_pkg::entry_t ent;

  logic cfg_wr;
  logic [31:0] diff;
  logic [31:0] off;
  logic free_bad;
  logic [SW:0] need_in;
  logic [SW:0] sum_gb;
  logic [SW:0] sum_gn;
  logic [SW-1:0] remain;
  logic [SW:0] bs_sum;

  ffba_ram #(.WIDTH(ffba_pkg::ENTRY_W), .DEPTH(ffba_pkg::GRAN_COUNT)) u_table (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  assign ent = ffba_pkg::entry_t'(ram_rdata);
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = paddr[2] ? {18'd0, pool_granules} : pool_base;

  assign req.ready = (state == S_IDLE) && !cfg_wr;
  assign rsp.valid = out_valid;
  assign rsp.status = out_status;
  assign rsp.address_res = out_addr;

  assign diff = req.address - pool_base;
  assign off = diff - ffba_pkg::HDR_SPAN;
  assign free_bad = (diff < ffba_pkg::HDR_SPAN) || (off[2:0] != 3'd0)
                    || (off[31:3] >= {15'd0, pool_len});
  assign need_in = (SW + 1)'(ffba_pkg::HDR_GRAN)
                   + (SW + 1)'((17'(req.size_bytes) + 17'd7) >> 3);
  assign sum_gb = {1'b0, g} + {1'b0, ent.size};
  assign sum_gn = {1'b0, g} + needed;
  assign remain = ent.size - needed[SW-1:0];
  assign bs_sum = {1'b0, aux} + {1'b0, ent.size};

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = g[AW-1:0];
    ram_wdata = '0;
    ram_raddr = g[AW-1:0];
    unique case (state)
      S_CLR: begin
        ram_we = 1'b1;
        ram_waddr = clr_cnt;
        if (clr_cnt == '0 && pool_len != '0) begin
          ram_wdata = {1'b1, 1'b0, pool_len};
        end
      end
      S_IDLE: begin
        ram_raddr = (req.req_type == ffba_pkg::REQ_FREE) ? off[AW+2:3] : '0;
      end
      S_A_CHK: begin
        ram_raddr = sum_gb[AW-1:0];
        if (ent.valid && ent.size != '0 && !ent.used && {1'b0, ent.size} >= needed
            && remain >= SW'(ffba_pkg::HDR_GRAN + 1) && sum_gn < {1'b0, pool_len}) begin
          ram_we = 1'b1;
          ram_waddr = sum_gn[AW-1:0];
          ram_wdata = {1'b1, 1'b0, remain};
        end
      end
      S_A_HEAD: begin
        ram_we = 1'b1;
        ram_wdata = {1'b1, 1'b1, bsz};
      end
      S_F_CHK: begin
        ram_raddr = sum_gb[AW-1:0];
      end
      S_F_NX: begin
        ram_waddr = aux[AW-1:0];
        ram_we = ent.valid && !ent.used;
      end
      S_F_WG: begin
        ram_we = 1'b1;
        ram_wdata = {1'b1, 1'b0, bsz};
        ram_raddr = '0;
      end
      S_F_PW: begin
        ram_raddr = bs_sum[AW-1:0];
        if (ent.valid && ent.size != '0 && bs_sum == {1'b0, g} && !ent.used) begin
          ram_we = 1'b1;
          ram_waddr = aux[AW-1:0];
          ram_wdata = {1'b1, 1'b0, SW'(ent.size + bsz)};
        end
      end
      S_F_CLRG: begin
        ram_we = 1'b1;
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      pool_base <= '0;
      pool_granules <= ffba_pkg::POOL_RESET;
      pool_len <= ffba_pkg::POOL_RESET;
      clr_cnt <= '1;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && !(state == S_DONE && !cfg_wr)) begin
        out_valid <= 1'b0;
      end
      if (cfg_wr) begin
        if (paddr[2]) begin
          pool_granules <= pwdata[SW-1:0];
          pool_len <= (pwdata[SW-1:0] > ffba_pkg::POOL_RESET) ? ffba_pkg::POOL_RESET
                                                              : pwdata[SW-1:0];
          clr_cnt <= '1;
          state <= S_CLR;
        end else begin
          pool_base <= pwdata;
        end
      end else begin
        unique case (state)
          S_CLR: begin
            clr_cnt <= clr_cnt - 1'b1;
            if (clr_cnt == '0) begin
              state <= S_IDLE;
            end
          end
          S_IDLE: begin
            res_addr <= '0;
            if (req.valid) begin
              g <= '0;
              needed <= need_in;
              if (req.req_type == ffba_pkg::REQ_ALLOC) begin
                if (req.size_bytes == '0) begin
                  res_status <= ffba_pkg::ST_NONE;
                  state <= S_DONE;
                end else if (pool_len == '0) begin
                  res_status <= ffba_pkg::ST_OOM;
                  state <= S_DONE;
                end else begin
                  state <= S_A_CHK;
                end
              end else begin
                if (req.address == '0) begin
                  res_status <= ffba_pkg::ST_NONE;
                  state <= S_DONE;
                end else if (free_bad) begin
                  res_status <= ffba_pkg::ST_BAD;
                  state <= S_DONE;
                end else begin
                  g <= off[SW+2:3];
                  state <= S_F_CHK;
                end
              end
            end
          end
          S_A_CHK: begin
            if (!ent.valid || ent.size == '0) begin
              res_status <= ffba_pkg::ST_OOM;
              state <= S_DONE;
            end else if (!ent.used && {1'b0, ent.size} >= needed) begin
              bsz <= (remain >= SW'(ffba_pkg::HDR_GRAN + 1)) ? needed[SW-1:0] : ent.size;
              res_addr <= pool_base + {15'd0, g, 3'd0} + ffba_pkg::HDR_SPAN;
              state <= S_A_HEAD;
            end else if (sum_gb >= {1'b0, pool_len}) begin
              res_status <= ffba_pkg::ST_OOM;
              state <= S_DONE;
            end else begin
              g <= sum_gb[SW-1:0];
            end
          end
          S_A_HEAD: begin
            res_status <= ffba_pkg::ST_OK;
            state <= S_DONE;
          end
          S_F_CHK: begin
            bsz <= ent.size;
            aux <= sum_gb[SW-1:0];
            if (!ent.valid) begin
              res_status <= ffba_pkg::ST_BAD;
              state <= S_DONE;
            end else if (ent.size != '0 && sum_gb < {1'b0, pool_len}) begin
              state <= S_F_NX;
            end else begin
              state <= S_F_WG;
            end
          end
          S_F_NX: begin
            if (ent.valid && !ent.used) begin
              bsz <= bsz + ent.size;
            end
            state <= S_F_WG;
          end
          S_F_WG: begin
            res_status <= ffba_pkg::ST_OK;
            aux <= '0;
            state <= (g == '0) ? S_DONE : S_F_PW;
          end
          S_F_PW: begin
            if (!ent.valid || ent.size == '0) begin
              state <= S_DONE;
            end else if (bs_sum == {1'b0, g}) begin
              state <= ent.used ? S_DONE : S_F_CLRG;
            end else if (bs_sum < {1'b0, g}) begin
              aux <= bs_sum[SW-1:0];
            end else begin
              state <= S_DONE;
            end
          end
          S_F_CLRG: begin
            state <= S_DONE;
          end
          S_DONE: begin
            if (!out_valid || rsp.ready) begin
              out_valid <= 1'b1;
              out_status <= res_status;
              out_addr <= (res_status == ffba_pkg::ST_OK) ? res_addr : '0;
              state <= S_IDLE;
            end
          end
          default: begin
            state <= S_IDLE;
          end
        endcase
      end
    end
  end

endmodule

>>> hw/rtl/ffba_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module ffba_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/ffba_checker.sv
// Port-level checks of the first-fit block allocator, attached to the top level by bind.
// Depends on ffba_pkg and first_fit_block_allocator_core.
module ffba_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [1:0]  rsp_status,
  input logic [31:0] rsp_address_res
);

  a_fail_null: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != ffba_pkg::ST_OK |-> rsp_address_res == '0)
    else $error("failed request returned a nonzero pointer");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while the previous transfer is in progress");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_address_res))
    else $error("stalled response changed");

endmodule

bind first_fit_block_allocator_core ffba_checker u_ffba_checker (
  .clk(clk), .rst(rst), .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_status(rsp.status),
  .rsp_address_res(rsp.address_res)
);
